>>> sv/rotation_matrix_between_vectors_top_assert.svh
// ----------------------------------------------------------------------------
// Rotation matrix assertion macros
// Shared property shorthands for the rotation matrix checker.
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_BETWEEN_VECTORS_TOP_ASSERT_SVH
`define ROTATION_MATRIX_BETWEEN_VECTORS_TOP_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define RMBV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmbv implication check failed");

// next-cycle implication, also checked through reset
`define RMBV_ASSERT_NXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rmbv next-cycle check failed");

`endif

>>> sv/rmbv_pkg.sv
// ----------------------------------------------------------------------------
// rmbv_pkg
// Widths, types and helpers for the rotation matrix pipeline.
// ----------------------------------------------------------------------------
package rmbv_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int PROD_W    = 2 * IN_W;         // a_i * b_j
    localparam int CROSS_W   = PROD_W + 1;       // cross product component
    localparam int DOT_W     = PROD_W + 2;       // dot product and 1 + c
    localparam int V_W       = CROSS_W - FRAC_BITS + 1; // rounded v
    localparam int VV_W      = 2 * V_W;          // v_i * v_j
    localparam int MAG_W     = VV_W - 2;         // |K*K| entry
    localparam int NUM_W     = 52;               // |kk| << FRAC_BITS plus d/2
    localparam int DEN_W     = 32;               // positive d
    localparam int QB        = NUM_W - DEN_W;    // quotient bits kept
    localparam int DIV_LAT   = QB + 1;
    localparam int LAT       = 5 + DIV_LAT + 1;  // accept edge to strobe
    localparam int R_W       = QB + 4;           // entry before saturation
    localparam int N_LANE    = 6;                // distinct K*K entries

    typedef logic signed [IN_W-1:0] t_word;
    typedef logic signed [V_W-1:0]  t_v;

    typedef struct packed {
        logic              vld;
        logic              deg;
        logic [N_LANE-1:0] neg;
        t_v                v0;
        t_v                v1;
        t_v                v2;
    } t_side;

    function automatic t_word sat16(input logic signed [R_W-1:0] x);
        logic signed [R_W-1:0] hi;
        logic signed [R_W-1:0] lo;
        hi = R_W'(32767);
        lo = -R_W'(32768);
        if (x > hi) begin
            sat16 = 16'sh7fff;
        end else if (x < lo) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = x[IN_W-1:0];
        end
    endfunction

endpackage

>>> sv/rotation_matrix_between_vectors_top.sv
// ----------------------------------------------------------------------------
// rotation_matrix_between_vectors_top
// Rodrigues rotation matrix carrying unit vector a onto b, Q1.14 in and out.
// ----------------------------------------------------------------------------
// A start beat taken at an edge passes stages 1 to 5, the divider and the output register to o_valid.
// Throughput: one beat per cycle, every cycle; busy is low outside reset.
// The divider is a 20-stage quotient pipeline (one bit per stage) behind an input register.
// Reset (synchronous, active low) clears all valid bits; busy is high during it.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module rotation_matrix_between_vectors_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  rmbv_pkg::t_word i_from_x,
    input  rmbv_pkg::t_word i_from_y,
    input  rmbv_pkg::t_word i_from_z,
    input  rmbv_pkg::t_word i_to_x,
    input  rmbv_pkg::t_word i_to_y,
    input  rmbv_pkg::t_word i_to_z,
    output logic            o_valid,
    output rmbv_pkg::t_word o_r00,
    output rmbv_pkg::t_word o_r01,
    output rmbv_pkg::t_word o_r02,
    output rmbv_pkg::t_word o_r10,
    output rmbv_pkg::t_word o_r11,
    output rmbv_pkg::t_word o_r12,
    output rmbv_pkg::t_word o_r20,
    output rmbv_pkg::t_word o_r21,
    output rmbv_pkg::t_word o_r22,
    output logic            o_degenerate
);
    import rmbv_pkg::*;

    // ---------------- stage 1: nine 16x16 products ----------------
    // 0..5 feed the cross product, 6..8 the dot product
    logic                     r1_vld;
    logic signed [PROD_W-1:0] r1_p [9];
    logic                     accept;

    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_p[0] <= i_from_y * i_to_z;
        r1_p[1] <= i_from_z * i_to_y;
        r1_p[2] <= i_from_z * i_to_x;
        r1_p[3] <= i_from_x * i_to_z;
        r1_p[4] <= i_from_x * i_to_y;
        r1_p[5] <= i_from_y * i_to_x;
        r1_p[6] <= i_from_x * i_to_x;
        r1_p[7] <= i_from_y * i_to_y;
        r1_p[8] <= i_from_z * i_to_z;
    end

    // ---------------- stage 2: v = round(a x b), d = 1 + a.b ----------------
    logic signed [CROSS_W-1:0] n_vw [3];
    logic signed [CROSS_W-1:0] n_vr [3];
    logic signed [DOT_W-1:0]   n_d;
    logic                      r2_vld;
    logic                      r2_deg;
    t_v                        r2_v [3];
    logic [DEN_W-1:0]          r2_d;

    always_comb begin
        n_vw[0] = CROSS_W'(r1_p[0]) - CROSS_W'(r1_p[1]);
        n_vw[1] = CROSS_W'(r1_p[2]) - CROSS_W'(r1_p[3]);
        n_vw[2] = CROSS_W'(r1_p[4]) - CROSS_W'(r1_p[5]);
        for (int i = 0; i < 3; i++) begin
            // round half up: add one half, then floor
            n_vr[i] = (n_vw[i] + CROSS_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        end
        n_d = DOT_W'(r1_p[6]) + DOT_W'(r1_p[7]) + DOT_W'(r1_p[8])
            + DOT_W'(64'sd1 << (2 * FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r2_v[i] <= n_vr[i][V_W-1:0];
        end
        r2_d   <= n_d[DEN_W-1:0];
        r2_deg <= n_d[DOT_W-1] | (n_d == '0);
    end

    // ---------------- stage 3: v_i * v_j ----------------
    // 0:v0v0 1:v1v1 2:v2v2 3:v0v1 4:v0v2 5:v1v2
    logic                   r3_vld;
    logic                   r3_deg;
    t_v                     r3_v [3];
    logic [DEN_W-1:0]       r3_d;
    logic signed [VV_W-1:0] r3_vv [N_LANE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_vv[0] <= r2_v[0] * r2_v[0];
        r3_vv[1] <= r2_v[1] * r2_v[1];
        r3_vv[2] <= r2_v[2] * r2_v[2];
        r3_vv[3] <= r2_v[0] * r2_v[1];
        r3_vv[4] <= r2_v[0] * r2_v[2];
        r3_vv[5] <= r2_v[1] * r2_v[2];
        r3_v     <= r2_v;
        r3_d     <= r2_d;
        r3_deg   <= r2_deg;
    end

    // ---------------- stage 4: K*K entries as sign and magnitude ----------------
    // lanes 0..2 are the diagonal (-(sum of the other two squares)),
    // lanes 3..5 the off-diagonal pairs 01, 02, 12
    logic [MAG_W-1:0]  n_mag [N_LANE];
    logic [N_LANE-1:0] n_neg;
    logic              r4_vld;
    logic              r4_deg;
    t_v                r4_v [3];
    logic [DEN_W-1:0]  r4_d;
    logic [MAG_W-1:0]  r4_mag [N_LANE];
    logic [N_LANE-1:0] r4_neg;

    always_comb begin
        logic [VV_W-1:0] s0;
        logic [VV_W-1:0] s1;
        logic [VV_W-1:0] s2;
        logic [VV_W-1:0] ab;
        s0 = r3_vv[1] + r3_vv[2];
        s1 = r3_vv[0] + r3_vv[2];
        s2 = r3_vv[0] + r3_vv[1];
        n_mag[0] = s0[MAG_W-1:0];
        n_mag[1] = s1[MAG_W-1:0];
        n_mag[2] = s2[MAG_W-1:0];
        n_neg[2:0] = 3'b111;
        for (int l = 3; l < N_LANE; l++) begin
            n_neg[l] = r3_vv[l][VV_W-1];
            ab       = n_neg[l] ? -r3_vv[l] : r3_vv[l];
            n_mag[l] = ab[MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_mag <= n_mag;
        r4_neg <= n_neg;
        r4_v   <= r3_v;
        r4_d   <= r3_d;
        r4_deg <= r3_deg;
    end

    // ---------------- stage 5: dividend |kk| * one + d/2 ----------------
    logic [NUM_W-1:0] r5_num [N_LANE];
    logic [DEN_W-1:0] r5_d;
    t_side            r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side.vld <= 1'b0;
        end else begin
            r5_side.vld <= r4_vld;
        end
        for (int l = 0; l < N_LANE; l++) begin
            r5_num[l] <= (NUM_W'(r4_mag[l]) << FRAC_BITS) + NUM_W'(r4_d >> 1);
        end
        r5_d         <= r4_d;
        r5_side.deg  <= r4_deg;
        r5_side.neg  <= r4_neg;
        r5_side.v0   <= r4_v[0];
        r5_side.v1   <= r4_v[1];
        r5_side.v2   <= r4_v[2];
    end

    // ---------------- divider lanes plus matching side delay line ----------------
    logic [QB-1:0] w_quo [N_LANE];
    t_side         r_dl  [DIV_LAT];

    for (genvar l = 0; l < N_LANE; l++) begin : g_lane
        rmbv_div u_div (
            .i_clk (i_clk),
            .i_num (r5_num[l]),
            .i_den (r5_d),
            .o_quo (w_quo[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DIV_LAT; s++) begin
                r_dl[s].vld <= 1'b0;
            end
        end else begin
            r_dl[0].vld <= r5_side.vld;
            for (int s = 1; s < DIV_LAT; s++) begin
                r_dl[s].vld <= r_dl[s-1].vld;
            end
        end
        r_dl[0].deg <= r5_side.deg;
        r_dl[0].neg <= r5_side.neg;
        r_dl[0].v0  <= r5_side.v0;
        r_dl[0].v1  <= r5_side.v1;
        r_dl[0].v2  <= r5_side.v2;
        for (int s = 1; s < DIV_LAT; s++) begin
            r_dl[s].deg <= r_dl[s-1].deg;
            r_dl[s].neg <= r_dl[s-1].neg;
            r_dl[s].v0  <= r_dl[s-1].v0;
            r_dl[s].v1  <= r_dl[s-1].v1;
            r_dl[s].v2  <= r_dl[s-1].v2;
        end
    end

    // ---------------- output stage: R = I + K + K*K/d, saturate ----------------
    t_side                 w_sd;
    logic signed [R_W-1:0] n_q [N_LANE];
    logic signed [R_W-1:0] n_k0;
    logic signed [R_W-1:0] n_k1;
    logic signed [R_W-1:0] n_k2;
    logic signed [R_W-1:0] n_one;
    t_word                 n_r [9];
    logic                  r_vld;
    logic                  r_deg;
    t_word                 r_r [9];

    assign w_sd = r_dl[DIV_LAT-1];

    always_comb begin
        n_one = R_W'(1 << FRAC_BITS);
        n_k0  = R_W'(w_sd.v0);
        n_k1  = R_W'(w_sd.v1);
        n_k2  = R_W'(w_sd.v2);
        for (int l = 0; l < N_LANE; l++) begin
            n_q[l] = w_sd.neg[l] ? -R_W'({1'b0, w_quo[l]}) : R_W'({1'b0, w_quo[l]});
        end
        if (w_sd.deg) begin
            // opposite vectors: identity
            for (int e = 0; e < 9; e++) begin
                n_r[e] = '0;
            end
            n_r[0] = sat16(n_one);
            n_r[4] = sat16(n_one);
            n_r[8] = sat16(n_one);
        end else begin
            n_r[0] = sat16(n_one + n_q[0]);
            n_r[1] = sat16(n_q[3] - n_k2);
            n_r[2] = sat16(n_q[4] + n_k1);
            n_r[3] = sat16(n_q[3] + n_k2);
            n_r[4] = sat16(n_one + n_q[1]);
            n_r[5] = sat16(n_q[5] - n_k0);
            n_r[6] = sat16(n_q[4] - n_k1);
            n_r[7] = sat16(n_q[5] + n_k0);
            n_r[8] = sat16(n_one + n_q[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_sd.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r   <= n_r;
        r_deg <= w_sd.deg;
    end

    assign o_valid      = r_vld;
    assign o_degenerate = r_deg;
    assign o_r00        = r_r[0];
    assign o_r01        = r_r[1];
    assign o_r02        = r_r[2];
    assign o_r10        = r_r[3];
    assign o_r11        = r_r[4];
    assign o_r12        = r_r[5];
    assign o_r20        = r_r[6];
    assign o_r21        = r_r[7];
    assign o_r22        = r_r[8];

endmodule

>>> sv/rmbv_div.sv
// ----------------------------------------------------------------------------
// rmbv_div
// Pipelined restoring divider, one quotient bit per stage, clamps on overflow.
// ----------------------------------------------------------------------------
module rmbv_div (
    input  logic                        i_clk,
    input  logic [rmbv_pkg::NUM_W-1:0]  i_num,
    input  logic [rmbv_pkg::DEN_W-1:0]  i_den,
    output logic [rmbv_pkg::QB-1:0]     o_quo
);
    import rmbv_pkg::*;

    logic [DEN_W-1:0] r_rem [QB+1];
    logic [DEN_W-1:0] r_den [QB+1];
    logic [QB-1:0]    r_lo  [QB+1];
    logic [QB-1:0]    r_q   [QB+1];
    logic             r_ovf [QB+1];

    logic [DEN_W-1:0] n_rem [QB];
    logic             n_ge  [QB];

    always_comb begin
        logic [DEN_W:0] trial;
        for (int k = 0; k < QB; k++) begin
            trial    = {r_rem[k], r_lo[k][QB-1]};
            n_ge[k]  = (trial >= {1'b0, r_den[k]});
            n_rem[k] = n_ge[k] ? DEN_W'(trial - {1'b0, r_den[k]}) : trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num[NUM_W-1:QB];
        r_lo[0]  <= i_num[QB-1:0];
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= (i_num[NUM_W-1:QB] >= i_den);
        for (int k = 0; k < QB; k++) begin
            r_rem[k+1] <= n_rem[k];
            r_lo[k+1]  <= r_lo[k] << 1;
            r_den[k+1] <= r_den[k];
            r_q[k+1]   <= {r_q[k][QB-2:0], n_ge[k]};
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    // quotient too large for QB bits: clamp, the entry saturates anyway
    assign o_quo = r_ovf[QB] ? '1 : r_q[QB];

endmodule

>>> sv/rmbv_chk.sv
// ----------------------------------------------------------------------------
// rmbv_chk
// Port-level checks for the rotation matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`include "rotation_matrix_between_vectors_top_assert.svh"

module rmbv_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input rmbv_pkg::t_word o_r00,
    input rmbv_pkg::t_word o_r01,
    input rmbv_pkg::t_word o_r02,
    input rmbv_pkg::t_word o_r10,
    input rmbv_pkg::t_word o_r11,
    input rmbv_pkg::t_word o_r12,
    input rmbv_pkg::t_word o_r20,
    input rmbv_pkg::t_word o_r21,
    input rmbv_pkg::t_word o_r22,
    input logic            o_valid,
    input logic            o_degenerate
);
    import rmbv_pkg::*;

    logic w_ident;

    // result ports hold the identity matrix
    assign w_ident = (o_r00 == 16'sd16384) && (o_r11 == 16'sd16384)
                  && (o_r22 == 16'sd16384)
                  && (o_r01 == '0) && (o_r02 == '0) && (o_r10 == '0)
                  && (o_r12 == '0) && (o_r20 == '0) && (o_r21 == '0);

    // reset empties the pipeline
    `RMBV_ASSERT_NXT(a_rst_flush, i_clk, !i_rst_n, !o_valid)

    // every strobe goes back to one taken beat, LAT (accept edge to strobe) earlier
    `RMBV_ASSERT_IMP(a_latency, i_clk, i_rst_n, o_valid, $past(start && !busy, LAT))

    // opposite vectors give the identity
    `RMBV_ASSERT_IMP(a_degen_ident, i_clk, i_rst_n, o_valid && o_degenerate, w_ident)

endmodule

bind rotation_matrix_between_vectors_top rmbv_chk u_rmbv_chk (.*);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix block testbench
// Drives vector pairs through the command port, predicts each Rodrigues
// matrix in fixed point and checks every strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
    import rmbv_pkg::*;

    localparam int N_RANDOM   = 550;
    localparam int TAIL_ITEMS = 60;   // no idling once this few are left
    localparam int STALL_MAX  = 2000; // cycles with no beat either way

    typedef struct {
        t_word a [3];
        t_word b [3];
    } t_pair;

    typedef struct {
        t_word m [9];
        logic  deg;
    } t_matrix;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_word i_from_x, i_from_y, i_from_z, i_to_x, i_to_y, i_to_z;
    logic  o_valid;
    t_word o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;
    logic  o_degenerate;

    t_pair   pair_q [$];
    t_matrix matrix_q [$];
    int      n_err;
    int      n_sent;
    int      n_checked;
    int      n_degen;
    int      idle_left;
    int      stall_cnt;

    rotation_matrix_between_vectors_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_from_x     (i_from_x),
        .i_from_y     (i_from_y),
        .i_from_z     (i_from_z),
        .i_to_x       (i_to_x),
        .i_to_y       (i_to_y),
        .i_to_z       (i_to_z),
        .o_valid      (o_valid),
        .o_r00        (o_r00),
        .o_r01        (o_r01),
        .o_r02        (o_r02),
        .o_r10        (o_r10),
        .o_r11        (o_r11),
        .o_r12        (o_r12),
        .o_r20        (o_r20),
        .o_r21        (o_r21),
        .o_r22        (o_r22),
        .o_degenerate (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // saturate to a 16-bit entry
    function automatic t_word clip16(input longint x);
        if (x > 32767) begin
            return 16'sh7fff;
        end else if (x < -32768) begin
            return 16'sh8000;
        end
        return t_word'(x);
    endfunction

    // nearest, ties away from zero; den > 0
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -q : q;
    endfunction

    // Rodrigues: R = I + K + K*K / (1 + c), K the skew matrix of a x b
    function automatic t_matrix rodrigues(input t_pair p);
        t_matrix r;
        longint  a [3];
        longint  b [3];
        longint  cr [3];
        longint  v [3];
        longint  k [9];
        longint  one;
        longint  d;
        longint  sq;
        longint  kk;
        one = longint'(1) << FRAC_BITS;
        for (int i = 0; i < 3; i++) begin
            a[i] = p.a[i];
            b[i] = p.b[i];
        end
        cr[0] = a[1] * b[2] - a[2] * b[1];
        cr[1] = a[2] * b[0] - a[0] * b[2];
        cr[2] = a[0] * b[1] - a[1] * b[0];
        d = (longint'(1) << (2 * FRAC_BITS)) + a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        if (d <= 0) begin
            // opposite vectors: identity, flagged
            for (int i = 0; i < 9; i++) r.m[i] = (i % 4 == 0) ? clip16(one) : '0;
            r.deg = 1'b1;
            return r;
        end
        // round half up to FRAC_BITS (>>> floors)
        for (int i = 0; i < 3; i++) v[i] = (cr[i] + (one >>> 1)) >>> FRAC_BITS;
        k = '{0, -v[2], v[1], v[2], 0, -v[0], -v[1], v[0], 0};
        sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                kk = v[i] * v[j] - ((i == j) ? sq : 0);
                r.m[i*3+j] = clip16(((i == j) ? one : 0) + k[i*3+j]
                                    + div_nearest(kk * one, d));
            end
        end
        r.deg = 1'b0;
        return r;
    endfunction

    function automatic t_pair make_pair(input int ax, ay, az, bx, by, bz);
        t_pair p;
        p.a = '{t_word'(ax), t_word'(ay), t_word'(az)};
        p.b = '{t_word'(bx), t_word'(by), t_word'(bz)};
        return p;
    endfunction

    function automatic int q14(input real x);
        return $rtoi(x * 16384.0 + ((x >= 0.0) ? 0.5 : -0.5));
    endfunction

    // random unit vector, Q1.14
    task automatic unit_vec(output int x, output int y, output int z);
        real th;
        real ph;
        th = $urandom_range(0, 62831) / 10000.0;
        ph = $urandom_range(0, 31415) / 10000.0;
        x = q14($sin(ph) * $cos(th));
        y = q14($sin(ph) * $sin(th));
        z = q14($cos(ph));
    endtask

    // stimulus: directed corners, then a random mix
    initial begin
        int ax, ay, az, bx, by, bz;
        int sel;
        i_rst_n = 1'b0;
        // same vector, quarter turns about each axis
        pair_q.push_back(make_pair(16384, 0, 0, 16384, 0, 0));
        pair_q.push_back(make_pair(16384, 0, 0, 0, 16384, 0));
        pair_q.push_back(make_pair(0, 16384, 0, 0, 0, 16384));
        pair_q.push_back(make_pair(0, 0, 16384, 16384, 0, 0));
        pair_q.push_back(make_pair(0, -16384, 0, 16384, 0, 0));
        // opposite vectors: 1 + c exactly zero
        pair_q.push_back(make_pair(16384, 0, 0, -16384, 0, 0));
        pair_q.push_back(make_pair(0, 0, -16384, 0, 0, 16384));
        // 1 + c negative (oversized opposite)
        pair_q.push_back(make_pair(32767, 32767, 32767, -32768, -32768, -32768));
        // 1 + c just positive
        pair_q.push_back(make_pair(16384, 1, 0, -16383, 0, 0));
        // zero vectors
        pair_q.push_back(make_pair(0, 0, 0, 0, 0, 0));
        pair_q.push_back(make_pair(0, 0, 0, 16384, 16384, 16384));
        // field extremes, saturation
        pair_q.push_back(make_pair(-32768, 32767, -32768, 32767, -32768, 32767));
        pair_q.push_back(make_pair(32767, -32768, 0, 0, 32767, -32768));
        pair_q.push_back(make_pair(-16384, -16384, -16384, 16384, 16384, 16384));
        pair_q.push_back(make_pair(16384, 16384, 16384, 16384, 16384, 16384));
        pair_q.push_back(make_pair(-1, -1, -1, 1, 1, 1));
        pair_q.push_back(make_pair(11585, 11585, 0, 0, 11585, 11585));
        pair_q.push_back(make_pair(16384, 0, 0, 0, -16384, 0));
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 9);
            unit_vec(ax, ay, az);
            if (sel < 6) begin
                unit_vec(bx, by, bz);
            end else if (sel < 8) begin
                // near opposite, straddles the degenerate boundary
                bx = -ax + $urandom_range(0, 6) - 3;
                by = -ay + $urandom_range(0, 6) - 3;
                bz = -az + $urandom_range(0, 6) - 3;
            end else begin
                ax = $urandom_range(0, 65535) - 32768;
                ay = $urandom_range(0, 65535) - 32768;
                az = $urandom_range(0, 65535) - 32768;
                bx = $urandom_range(0, 65535) - 32768;
                by = $urandom_range(0, 65535) - 32768;
                bz = $urandom_range(0, 65535) - 32768;
            end
            pair_q.push_back(make_pair(ax, ay, az, bx, by, bz));
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (pair_q.size() != 0 || matrix_q.size() != 0);
        repeat (40) @(posedge i_clk);
        $display("%0d vector pairs sent, %0d matrices checked, %0d degenerate",
                 n_sent, n_checked, n_degen);
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // driver: one beat per accepted start, random idle bursts until the tail
    always @(posedge i_clk) begin
        logic go;
        if (start && !busy && i_rst_n) begin
            matrix_q.push_back(rodrigues(pair_q.pop_front()));
            n_sent <= n_sent + 1;
        end
        go = 1'b0;
        if (!i_rst_n || pair_q.size() == 0) begin
            idle_left <= 0;
        end else if (idle_left > 0) begin
            idle_left <= idle_left - 1;
        end else if (pair_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
            idle_left <= $urandom_range(1, 15) - 1;
        end else begin
            go = 1'b1;
        end
        start <= go && i_rst_n;
        if (pair_q.size() != 0) begin
            i_from_x <= pair_q[0].a[0];
            i_from_y <= pair_q[0].a[1];
            i_from_z <= pair_q[0].a[2];
            i_to_x   <= pair_q[0].b[0];
            i_to_y   <= pair_q[0].b[1];
            i_to_z   <= pair_q[0].b[2];
        end
    end

    // monitor: every strobed result against the oldest expectation
    always @(posedge i_clk) begin
        t_matrix want;
        t_word   got [9];
        if (i_rst_n && o_valid) begin
            if (matrix_q.size() == 0) begin
                $error("result beat with no expectation pending");
                n_err++;
            end else begin
                want = matrix_q.pop_front();
                got = '{o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22};
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== want.m[i]) begin
                        $error("r%0d%0d: expected %0d, got %0d",
                               i / 3, i % 3, want.m[i], got[i]);
                        n_err++;
                    end
                end
                if (o_degenerate !== want.deg) begin
                    $error("degenerate: expected %0b, got %0b", want.deg, o_degenerate);
                    n_err++;
                end
                n_checked++;
                if (want.deg) n_degen++;
            end
        end
    end

    // watchdog: too long with no beat on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_MAX) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        start     = 1'b0;
        i_from_x  = '0;
        i_from_y  = '0;
        i_from_z  = '0;
        i_to_x    = '0;
        i_to_y    = '0;
        i_to_z    = '0;
        n_err     = 0;
        n_sent    = 0;
        n_checked = 0;
        n_degen   = 0;
        idle_left = 0;
        stall_cnt = 0;
    end
endmodule
